[hdl/rba_pkg.sv]
// ----------------------------------------------------------------------------
// rba_pkg: shared types and constants for the region bump allocator table
// Holds request kinds, status codes, sequencer states and table entry layout.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int unsigned ADDR_W           = 32;
  localparam int unsigned PAGES_W          = 21;
  localparam int unsigned DEF_REGION_SLOTS = 256;
  localparam int unsigned DEF_PAGE_BYTES   = 4096;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  start_address;
    logic               legitimate;
    logic [ADDR_W-1:0]  freed_base;
    logic [PAGES_W-1:0] freed_pages;
    logic               flush_tlb;
  } result_t;

endpackage

[hdl/rba_table_mem.sv]
// ----------------------------------------------------------------------------
// rba_table_mem: region table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rba_table_mem #(
  parameter int unsigned Depth = rba_pkg::DEF_REGION_SLOTS,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  rba_pkg::entry_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_addr_i,
  output rba_pkg::entry_t      rd_data_o
);

  rba_pkg::entry_t mem_q [Depth];
  rba_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/rba_ctrl.sv]
// ----------------------------------------------------------------------------
// rba_ctrl: request sequencer with one shared add/compare unit
// Walks the region table one entry per cycle for release and check.
// ----------------------------------------------------------------------------
module rba_ctrl #(
  parameter int unsigned MaxRegions = rba_pkg::DEF_REGION_SLOTS,
  parameter int unsigned PageBytes  = rba_pkg::DEF_PAGE_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rba_pkg::ADDR_W-1:0]  pool_base_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [rba_pkg::ADDR_W-1:0]  size_i,
  input  logic [rba_pkg::ADDR_W-1:0]  addr_i,
  output logic                        res_valid_o,
  output rba_pkg::result_t            res_o,
  input  logic                        res_take_i
);

  localparam int unsigned IdxW      = $clog2(MaxRegions);
  localparam int unsigned CntW      = $clog2(MaxRegions + 1);
  localparam int unsigned PageShift = $clog2(PageBytes);
  localparam int unsigned AW        = rba_pkg::ADDR_W;
  localparam int unsigned PW        = rba_pkg::PAGES_W;
  localparam logic [CntW-1:0] CntMax   = CntW'(MaxRegions);
  localparam logic [AW-1:0]   PagesSat = AW'({PW{1'b1}});

  rba_pkg::state_e   state_q, state_d;
  rba_pkg::kind_e    kind_q, kind_d;
  logic [AW-1:0]     size_q, size_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [CntW-1:0]   total_q, total_d;
  logic [CntW-1:0]   idx_q, idx_d;
  rba_pkg::result_t  res_q, res_d;

  logic              rd_en, wr_en;
  logic [IdxW-1:0]   rd_addr, wr_addr;
  rba_pkg::entry_t   wr_data, rd_data;

  // shared unit: one 33-bit add and the compares hung off it
  logic [AW:0]       sum;
  logic              hit_eq, hit_rng;
  logic [AW-1:0]     pages_raw;
  logic [PW-1:0]     pages;
  logic [CntW-1:0]   idx_p1, idx_p2, total_m1;

  assign sum       = {1'b0, rd_data.base} + {1'b0, rd_data.size};
  assign hit_eq    = (rd_data.base == addr_q);
  assign hit_rng   = (addr_q >= rd_data.base) && ({1'b0, addr_q} < sum);
  assign pages_raw = rd_data.size >> PageShift;
  assign pages     = (pages_raw > PagesSat) ? {PW{1'b1}} : pages_raw[PW-1:0];
  assign idx_p1    = idx_q + CntW'(1);
  assign idx_p2    = idx_q + CntW'(2);
  assign total_m1  = total_q - CntW'(1);

  rba_table_mem #(
    .Depth (MaxRegions)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rba_pkg::S_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    size_q <= size_d;
    addr_q <= addr_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    size_d     = size_q;
    addr_d     = addr_q;
    total_d    = total_q;
    idx_d      = idx_q;
    res_d      = res_q;
    rd_en      = 1'b0;
    rd_addr    = idx_p1[IdxW-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx_q[IdxW-1:0];
    wr_data    = rd_data;
    in_ready_o = (state_q == rba_pkg::S_IDLE);

    case (state_q)
      rba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          kind_d = rba_pkg::kind_e'(kind_i);
          size_d = size_i;
          addr_d = addr_i;
          idx_d  = '0;
          res_d  = '0;
          state_d = rba_pkg::S_RESP;
          case (rba_pkg::kind_e'(kind_i))
            rba_pkg::KIND_ALLOC: begin
              if (size_i == '0) begin
                res_d.status = rba_pkg::ST_ZERO_SIZE;
              end else if (total_q == CntMax) begin
                res_d.status = rba_pkg::ST_FULL;
              end else if (total_q == '0) begin
                // empty table: first region sits at the pool base
                wr_en              = 1'b1;
                wr_addr            = '0;
                wr_data.base       = pool_base_i;
                wr_data.size       = size_i;
                total_d            = total_q + CntW'(1);
                res_d.start_address = pool_base_i;
              end else begin
                rd_en   = 1'b1;
                rd_addr = total_m1[IdxW-1:0];
                state_d = rba_pkg::S_ALLOC_RD;
              end
            end
            rba_pkg::KIND_RELEASE, rba_pkg::KIND_CHECK: begin
              if (total_q == '0) begin
                if (rba_pkg::kind_e'(kind_i) == rba_pkg::KIND_RELEASE) begin
                  res_d.status = rba_pkg::ST_NOT_FOUND;
                end
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = rba_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      rba_pkg::S_ALLOC_RD: begin
        // append right after the last region, end taken modulo 2^32
        wr_en               = 1'b1;
        wr_addr             = total_q[IdxW-1:0];
        wr_data.base        = sum[AW-1:0];
        wr_data.size        = size_q;
        total_d             = total_q + CntW'(1);
        res_d.start_address = sum[AW-1:0];
        state_d             = rba_pkg::S_RESP;
      end

      rba_pkg::S_SCAN: begin
        if (kind_q == rba_pkg::KIND_RELEASE) begin
          if (hit_eq) begin
            res_d.freed_base  = rd_data.base;
            res_d.freed_pages = pages;
            res_d.flush_tlb   = 1'b1;
            if (idx_p1 == total_q) begin
              total_d = total_m1;
              state_d = rba_pkg::S_RESP;
            end else begin
              rd_en   = 1'b1;
              state_d = rba_pkg::S_SHIFT;
            end
          end else if (idx_p1 == total_q) begin
            res_d.status = rba_pkg::ST_NOT_FOUND;
            state_d      = rba_pkg::S_RESP;
          end else begin
            rd_en = 1'b1;
            idx_d = idx_p1;
          end
        end else begin
          if (hit_rng) begin
            res_d.legitimate = 1'b1;
            state_d          = rba_pkg::S_RESP;
          end else if (idx_p1 == total_q) begin
            state_d = rba_pkg::S_RESP;
          end else begin
            rd_en = 1'b1;
            idx_d = idx_p1;
          end
        end
      end

      rba_pkg::S_SHIFT: begin
        // move entry idx+1 down to idx
        wr_en = 1'b1;
        if (idx_p2 == total_q) begin
          total_d = total_m1;
          state_d = rba_pkg::S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[IdxW-1:0];
          idx_d   = idx_p1;
        end
      end

      rba_pkg::S_RESP: begin
        if (res_take_i) begin
          state_d = rba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rba_pkg::S_IDLE;
      end
    endcase
  end

  assign res_valid_o = (state_q == rba_pkg::S_RESP);
  assign res_o       = res_q;

endmodule

[hdl/region_bump_allocator_table.sv]
// ----------------------------------------------------------------------------
// region_bump_allocator_table: bump allocator over a table of virtual regions
// Allocate appends a region, release finds and compacts it out, check probes
// an address against each region in turn until one holds it.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | beat carries
//  ---------+-----------+------------------------+------------------------------
//  cfg      | in        | cfg_valid_i/cfg_ready_o| pool_base (cfg_data_i)
//  in       | in        | in_valid_i/in_ready_o  | kind_i, size_bytes_i, address_i
//  out      | out       | out_valid_o/out_ready_i| status_o ... flush_tlb_o
//
//  Allocate reads at most the last entry; check and release walk the table
//  memory one entry per cycle, and a release compacts the entries above the
//  hit as the walk goes on.
//  Reset clears the region count and the pool base; the table itself is not
//  cleared, since only entries below the count are ever read.
//  A result waits in the output register, so the sequencer can finish the next
//  beat in an out stall; the next input beat is taken as soon as it is idle.
//  Configuration is always ready and must only be written while idle.
//
module region_bump_allocator_table #(
  parameter int unsigned REGION_SLOTS = rba_pkg::DEF_REGION_SLOTS,
  parameter int unsigned PAGE_BYTES   = rba_pkg::DEF_PAGE_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rba_pkg::ADDR_W-1:0]   cfg_data_i,
  // request
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [rba_pkg::ADDR_W-1:0]   size_bytes_i,
  input  logic [rba_pkg::ADDR_W-1:0]   address_i,
  // result
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [rba_pkg::ADDR_W-1:0]   start_address_o,
  output logic                         legitimate_o,
  output logic [rba_pkg::ADDR_W-1:0]   freed_base_o,
  output logic [rba_pkg::PAGES_W-1:0]  freed_pages_o,
  output logic                         flush_tlb_o
);

  logic [rba_pkg::ADDR_W-1:0] pool_base_q;
  logic                       out_valid_q;
  rba_pkg::result_t           out_q;
  logic                       res_valid;
  logic                       res_take;
  rba_pkg::result_t           res;

  // pool base register, written from the config channel
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_valid_i) begin
      pool_base_q <= cfg_data_i;
    end
  end

  rba_ctrl #(
    .MaxRegions (REGION_SLOTS),
    .PageBytes  (PAGE_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pool_base_i (pool_base_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .size_i      (size_bytes_i),
    .addr_i      (address_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // advance a finished result into the output register once it is free
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign start_address_o = out_q.start_address;
  assign legitimate_o    = out_q.legitimate;
  assign freed_base_o    = out_q.freed_base;
  assign freed_pages_o   = out_q.freed_pages;
  assign flush_tlb_o     = out_q.flush_tlb;

endmodule
